### src/q2e_pkg.sv
// Shared types, constants and tables for the quaternion to Euler angle converter.
package q2e_pkg;

    localparam int unsigned DefAngleFracBits = 7;
    localparam int unsigned CordicSteps      = 21;
    localparam int unsigned OpWidth          = 44;
    localparam int unsigned AngWidth         = 26;
    localparam int unsigned RadWidth         = 58;
    localparam int unsigned ProdWidth        = 36;
    localparam int unsigned NormWidth        = 6;

    localparam logic signed [OpWidth-1:0]   NormLimit = 44'sd1 << 40;
    localparam logic signed [ProdWidth-1:0] Q28One    = 36'sd1 << 28;
    localparam logic signed [AngWidth-1:0]  Deg90     = 26'sd5898240;

    typedef logic signed [OpWidth-1:0]  t_op;
    typedef logic signed [AngWidth-1:0] t_ang;

    typedef struct packed {
        t_op  x;
        t_op  y;
        t_ang z;
    } t_cordic;

    function automatic t_ang atan_deg(input int unsigned idx);
        t_ang r;
        unique case (idx)
            0:  r = 26'sd2949120;
            1:  r = 26'sd1740967;
            2:  r = 26'sd919879;
            3:  r = 26'sd466945;
            4:  r = 26'sd234379;
            5:  r = 26'sd117304;
            6:  r = 26'sd58666;
            7:  r = 26'sd29335;
            8:  r = 26'sd14668;
            9:  r = 26'sd7334;
            10: r = 26'sd3667;
            11: r = 26'sd1833;
            12: r = 26'sd917;
            13: r = 26'sd458;
            14: r = 26'sd229;
            15: r = 26'sd115;
            16: r = 26'sd57;
            17: r = 26'sd29;
            18: r = 26'sd14;
            19: r = 26'sd7;
            20: r = 26'sd4;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### src/q2e_isqrt.sv
// Pipelined bit-by-bit square root of 2^56 - s^2, two result bits per stage, one in the last stage.
module q2e_isqrt (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [q2e_pkg::ProdWidth-1:0]   i_s,
    input  logic        [57:0]                     i_sq,
    output logic signed [q2e_pkg::ProdWidth-1:0]   o_s,
    output logic        [28:0]                     o_root
);
    localparam int unsigned Stages = 15;

    logic [57:0] r_v   [Stages+1];
    logic [57:0] r_res [Stages+1];
    logic signed [q2e_pkg::ProdWidth-1:0] r_s [Stages+1];

    always_comb begin
        r_v[0]   = (58'd1 << 56) - i_sq;
        r_res[0] = '0;
        r_s[0]   = i_s;
    end

    genvar g;
    generate
        for (g = 0; g < Stages; g++) begin : g_st
            logic [57:0] n_v, n_res, bit0, bit1, t;
            always_comb begin
                bit0 = 58'd1 << (56 - 4 * g);
                bit1 = bit0 >> 2;
                n_v = r_v[g];
                n_res = r_res[g];
                t = n_res + bit0;
                if (n_v >= t) begin
                    n_v = n_v - t;
                    n_res = (n_res >> 1) + bit0;
                end else begin
                    n_res = n_res >> 1;
                end
                if (g < Stages - 1) begin
                    t = n_res + bit1;
                    if (n_v >= t) begin
                        n_v = n_v - t;
                        n_res = (n_res >> 1) + bit1;
                    end else begin
                        n_res = n_res >> 1;
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[g+1]   <= n_v;
                    r_res[g+1] <= n_res;
                    r_s[g+1]   <= r_s[g];
                end
            end
        end
    endgenerate

    assign o_s    = r_s[Stages];
    assign o_root = r_res[Stages][28:0];
endmodule

### src/q2e_cordic.sv
// Unrolled vectoring CORDIC for atan2: normalize, quadrant fold, one step per stage.
module q2e_cordic (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  q2e_pkg::t_op          i_y,
    input  q2e_pkg::t_op          i_x,
    output q2e_pkg::t_ang         o_ang
);
    localparam int unsigned N = q2e_pkg::CordicSteps;

    q2e_pkg::t_cordic r_st [N+1];
    logic [N:0]       r_zero;
    q2e_pkg::t_op     r_nx, r_ny;
    logic             r_nz;

    function automatic logic [q2e_pkg::NormWidth-1:0] lead_shift(input q2e_pkg::t_op a,
                                                                 input q2e_pkg::t_op b);
        logic [q2e_pkg::OpWidth-1:0] ma, mb, m;
        logic [q2e_pkg::NormWidth-1:0] s;
        ma = a[q2e_pkg::OpWidth-1] ? -a : a;
        mb = b[q2e_pkg::OpWidth-1] ? -b : b;
        m  = ma | mb;
        s  = '0;
        for (int k = 0; k <= 40; k++) begin
            if (m[k]) s = q2e_pkg::NormWidth'(40 - k);
        end
        return s;
    endfunction

    // normalize stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx <= i_x <<< lead_shift(i_x, i_y);
            r_ny <= i_y <<< lead_shift(i_x, i_y);
            r_nz <= (i_x == '0) && (i_y == '0);
        end
    end

    // fold left half plane into right
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= {r_zero[N-1:0], r_nz};
            if (r_nx < 0) begin
                if (r_ny >= 0) begin
                    r_st[0].x <= r_ny;
                    r_st[0].y <= -r_nx;
                    r_st[0].z <= q2e_pkg::Deg90;
                end else begin
                    r_st[0].x <= -r_ny;
                    r_st[0].y <= r_nx;
                    r_st[0].z <= -q2e_pkg::Deg90;
                end
            end else begin
                r_st[0].x <= r_nx;
                r_st[0].y <= r_ny;
                r_st[0].z <= '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_it
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_st[g].y >= 0) begin
                        r_st[g+1].x <= r_st[g].x + (r_st[g].y >>> g);
                        r_st[g+1].y <= r_st[g].y - (r_st[g].x >>> g);
                        r_st[g+1].z <= r_st[g].z + q2e_pkg::atan_deg(g);
                    end else begin
                        r_st[g+1].x <= r_st[g].x - (r_st[g].y >>> g);
                        r_st[g+1].y <= r_st[g].y + (r_st[g].x >>> g);
                        r_st[g+1].z <= r_st[g].z - q2e_pkg::atan_deg(g);
                    end
                end
            end
        end
    endgenerate

    assign o_ang = r_zero[N] ? '0 : r_st[N].z;
endmodule

### src/quaternion_to_euler_angles_top.sv
// Top level: product terms, square root, three CORDIC units and output formatting.
//
//  channel   direction  handshake          payload
//  in        input      i_valid / o_stall  i_quat_real, i_quat_i, i_quat_j, i_quat_k
//  out       output     o_valid / i_stall  o_roll_angle, o_pitch_angle, o_yaw_angle
//  cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_data (yaw_invert)
//
// One quaternion per cycle while the pipeline is not stalled; from the accepting edge to
// o_valid it passes products, sine terms, sine square, square root, normalize and fold,
// CORDIC steps, and the format and output register.
// The whole pipeline advances only when the output register is free; i_stall freezes
// every stage, so o_stall follows i_stall while the output holds a transaction.
// Reset clears valid bits and yaw_invert; payload registers are not reset.
module quaternion_to_euler_angles_top #(
    parameter int unsigned ANGLE_FRAC_BITS = q2e_pkg::DefAngleFracBits
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_real,
    input  logic signed [15:0] i_quat_i,
    input  logic signed [15:0] i_quat_j,
    input  logic signed [15:0] i_quat_k,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    localparam int unsigned PW  = q2e_pkg::ProdWidth;
    localparam int unsigned Lat = 2 + 15 + 2 + q2e_pkg::CordicSteps + 1;
    localparam int unsigned Sh  = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [q2e_pkg::AngWidth-1:0] Half =
        q2e_pkg::AngWidth'(1) <<< (15 - ANGLE_FRAC_BITS);
    localparam logic signed [q2e_pkg::AngWidth-1:0] Lim180 =
        q2e_pkg::AngWidth'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [q2e_pkg::AngWidth-1:0] Lim90 =
        q2e_pkg::AngWidth'(90) <<< ANGLE_FRAC_BITS;

    logic en;
    logic r_yaw_inv;
    logic [Lat-1:0] r_vld;
    logic r_ovld;

    assign en          = !(r_ovld && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_inv <= 1'b0;
            r_vld     <= '0;
            r_ovld    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_yaw_inv <= i_cfg_data;
            if (en) begin
                r_vld  <= {r_vld[Lat-2:0], i_valid};
                r_ovld <= r_vld[Lat-1];
            end
        end
    end

    // stage 1: raw products
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat_real * i_quat_i;
            r_yz <= i_quat_j * i_quat_k;
            r_xx <= i_quat_i * i_quat_i;
            r_yy <= i_quat_j * i_quat_j;
            r_wy <= i_quat_real * i_quat_j;
            r_zx <= i_quat_k * i_quat_i;
            r_wz <= i_quat_real * i_quat_k;
            r_xy <= i_quat_i * i_quat_j;
            r_zz <= i_quat_k * i_quat_k;
        end
    end

    // stage 2: combined terms, sine saturation
    logic signed [PW-1:0] r_rn, r_rd, r_yn, r_yd, r_s, s_raw, s_sat;
    always_comb begin
        s_raw = PW'(2) * (PW'(r_wy) - PW'(r_zx));
        if (s_raw > q2e_pkg::Q28One)       s_sat = q2e_pkg::Q28One;
        else if (s_raw < -q2e_pkg::Q28One) s_sat = -q2e_pkg::Q28One;
        else                               s_sat = s_raw;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rn <= PW'(2) * (PW'(r_wx) + PW'(r_yz));
            r_rd <= q2e_pkg::Q28One - PW'(2) * (PW'(r_xx) + PW'(r_yy));
            r_yn <= PW'(2) * (PW'(r_wz) + PW'(r_xy));
            r_yd <= q2e_pkg::Q28One - PW'(2) * (PW'(r_yy) + PW'(r_zz));
            r_s  <= s_sat;
        end
    end

    // stage 3: sine squared; the saturated magnitude fits in 29 bits
    logic signed [PW-1:0] r_s2, s_abs;
    logic [57:0] r_sq;
    assign s_abs = r_s[PW-1] ? -r_s : r_s;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2 <= r_s;
            r_sq <= s_abs[28:0] * s_abs[28:0];
        end
    end

    logic signed [PW-1:0] s_dly;
    logic [28:0] root;
    q2e_isqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_s(r_s2), .i_sq(r_sq),
        .o_s(s_dly), .o_root(root)
    );

    // delay roll/yaw operands to line up with the square root
    localparam int unsigned D = 16;
    logic signed [PW-1:0] r_drn [D], r_drd [D], r_dyn [D], r_dyd [D];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drn[0] <= r_rn; r_drd[0] <= r_rd;
            r_dyn[0] <= r_yn; r_dyd[0] <= r_yd;
            for (int k = 1; k < D; k++) begin
                r_drn[k] <= r_drn[k-1]; r_drd[k] <= r_drd[k-1];
                r_dyn[k] <= r_dyn[k-1]; r_dyd[k] <= r_dyd[k-1];
            end
        end
    end

    q2e_pkg::t_ang a_roll, a_pitch, a_yaw;
    q2e_cordic u_roll (.i_clk(i_clk), .i_en(en),
        .i_y(q2e_pkg::OpWidth'(r_drn[D-1])), .i_x(q2e_pkg::OpWidth'(r_drd[D-1])),
        .o_ang(a_roll));
    q2e_cordic u_pitch (.i_clk(i_clk), .i_en(en),
        .i_y(q2e_pkg::OpWidth'(s_dly)), .i_x(q2e_pkg::OpWidth'({1'b0, root})),
        .o_ang(a_pitch));
    q2e_cordic u_yaw (.i_clk(i_clk), .i_en(en),
        .i_y(q2e_pkg::OpWidth'(r_dyn[D-1])), .i_x(q2e_pkg::OpWidth'(r_dyd[D-1])),
        .o_ang(a_yaw));

    // formatting
    q2e_pkg::t_ang f_roll, f_pitch, f_yaw, c_roll, c_pitch, c_yaw;
    always_comb begin
        f_roll  = (a_roll + Half) >>> Sh;
        f_pitch = (a_pitch + Half) >>> Sh;
        f_yaw   = (a_yaw + Half) >>> Sh;
        c_roll  = (f_roll > Lim180) ? Lim180 : (f_roll < -Lim180) ? -Lim180 : f_roll;
        c_pitch = (f_pitch > Lim90) ? Lim90 : (f_pitch < -Lim90) ? -Lim90 : f_pitch;
        c_yaw   = r_yaw_inv ? -f_yaw : f_yaw;
        if (c_yaw > Lim180)       c_yaw = c_yaw - (Lim180 <<< 1);
        else if (c_yaw < -Lim180) c_yaw = c_yaw + (Lim180 <<< 1);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_roll_angle  <= c_roll[15:0];
            o_pitch_angle <= c_pitch[14:0];
            o_yaw_angle   <= c_yaw[15:0];
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output transaction dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_yaw_angle))
        else $error("output changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");
endmodule
